### rtl/ops_pkg.sv
// Package for the opcode pattern scanner: field widths, register map, reset values
// and the fixed table of opcode byte patterns.
// No dependencies; every other file of the block refers to it by scoped names.
package ops_pkg;

	// Field widths
	localparam int BYTE_W    = 8;
	localparam int INDEX_W   = 5;
	localparam int ADDR_W    = 64;
	localparam int NUMBER_W  = 8;
	localparam int LENGTH_W  = 16;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 64;

	// Default window size and offsets kept clear of the scan tail
	localparam int WINDOW_BYTES_DEF = 5;
	localparam int TAIL_GUARD       = 16;

	// Register reset values
	localparam logic [ADDR_W-1:0]   BASE_RESET = '0;
	localparam logic [LENGTH_W-1:0] LEN_RESET  = 16'd400;
	localparam logic [NUMBER_W-1:0] MAX_RESET  = 8'd50;

	// Register indexes, taken from paddr[4:3]
	typedef enum logic [1:0] {
		REG_BASE_ADDRESS = 2'd0,
		REG_SCAN_LENGTH  = 2'd1,
		REG_MAX_MATCHES  = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	// Result of comparing one window against the table
	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] index;
	} match_t;

	// Pattern table
	localparam int PATTERN_COUNT = 24;
	localparam int PAT_MAX       = 5;

	typedef logic [2:0]        pat_len_t;
	typedef logic [BYTE_W-1:0] pat_row_t [PAT_MAX];

	localparam pat_len_t PAT_LEN [PATTERN_COUNT] = '{
		3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5,
		3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2
	};

	localparam pat_row_t PAT_BYTES [PATTERN_COUNT] = '{
		'{8'h48, 8'h8d, 8'h04, 8'h89, 8'h00},
		'{8'h48, 8'h8d, 8'h04, 8'h49, 8'h00},
		'{8'h48, 8'h8d, 8'h04, 8'hc9, 8'h00},
		'{8'h48, 8'hc1, 8'he0, 8'h08, 8'h00},
		'{8'h48, 8'hc1, 8'he0, 8'h09, 8'h00},
		'{8'h48, 8'hc1, 8'he0, 8'h0a, 8'h00},
		'{8'hb8, 8'h00, 8'h04, 8'h00, 8'h00},
		'{8'hb8, 8'h00, 8'h05, 8'h00, 8'h00},
		'{8'h48, 8'h39, 8'h00, 8'h00, 8'h00},
		'{8'h39, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h69, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h6b, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h48, 8'hf7, 8'h00, 8'h00, 8'h00},
		'{8'h0f, 8'h8c, 8'h00, 8'h00, 8'h00},
		'{8'h0f, 8'h8d, 8'h00, 8'h00, 8'h00},
		'{8'h0f, 8'h82, 8'h00, 8'h00, 8'h00},
		'{8'h0f, 8'h83, 8'h00, 8'h00, 8'h00},
		'{8'h0f, 8'h84, 8'h00, 8'h00, 8'h00},
		'{8'h0f, 8'h85, 8'h00, 8'h00, 8'h00},
		'{8'h48, 8'h01, 8'h00, 8'h00, 8'h00},
		'{8'h48, 8'h29, 8'h00, 8'h00, 8'h00},
		'{8'h48, 8'h21, 8'h00, 8'h00, 8'h00},
		'{8'h48, 8'h09, 8'h00, 8'h00, 8'h00},
		'{8'h48, 8'h31, 8'h00, 8'h00, 8'h00}
	};

endpackage

### rtl/ops_byte_if.sv
// Channel that carries code bytes into the scanner.
// Depends on ops_pkg for the byte width.
interface ops_byte_if;
	logic                       valid;
	logic                       ready;
	logic [ops_pkg::BYTE_W-1:0] code_byte;
	logic                       first;

	modport source (output valid, output code_byte, output first, input ready);
	modport sink (input valid, input code_byte, input first, output ready);
endinterface

### rtl/ops_match_if.sv
// Channel that carries match reports out of the scanner.
// Depends on ops_pkg for the field widths.
interface ops_match_if;
	logic                         valid;
	logic                         ready;
	logic [ops_pkg::INDEX_W-1:0]  pattern_index;
	logic [ops_pkg::ADDR_W-1:0]   match_address;
	logic [ops_pkg::NUMBER_W-1:0] match_number;

	modport source (output valid, output pattern_index, output match_address,
		output match_number, input ready);
	modport sink (input valid, input pattern_index, input match_address,
		input match_number, output ready);
endinterface

### rtl/ops_matcher.sv
// Parallel compare of one byte window against the fixed opcode pattern table.
// Depends on ops_pkg for the table and the match_t result type.
module ops_matcher #(
	parameter int WINDOW_BYTES = ops_pkg::WINDOW_BYTES_DEF
) (
	input  logic [ops_pkg::BYTE_W*WINDOW_BYTES-1:0] window,
	output ops_pkg::match_t                         result
);

	logic [ops_pkg::BYTE_W-1:0]       win_b [ops_pkg::PAT_MAX];
	logic [ops_pkg::PATTERN_COUNT-1:0] hits;

	// Pad the window up to the longest pattern; bytes beyond it never decide a hit
	for (genvar j = 0; j < ops_pkg::PAT_MAX; j++) begin : g_pad
		if (j < WINDOW_BYTES) begin : g_byte
			assign win_b[j] = window[ops_pkg::BYTE_W*j +: ops_pkg::BYTE_W];
		end else begin : g_zero
			assign win_b[j] = '0;
		end
	end

	// Compare every pattern; a pattern longer than the window never hits
	always_comb begin
		for (int p = 0; p < ops_pkg::PATTERN_COUNT; p++) begin
			hits[p] = (int'(ops_pkg::PAT_LEN[p]) <= WINDOW_BYTES);
			for (int j = 0; j < ops_pkg::PAT_MAX; j++) begin
				if (j < int'(ops_pkg::PAT_LEN[p])) begin
					hits[p] = hits[p] & (win_b[j] == ops_pkg::PAT_BYTES[p][j]);
				end
			end
		end
	end

	// Pick the lowest matching index
	always_comb begin
		result.hit   = |hits;
		result.index = '0;
		for (int p = ops_pkg::PATTERN_COUNT - 1; p >= 0; p--) begin
			if (hits[p]) begin
				result.index = ops_pkg::INDEX_W'(p);
			end
		end
	end

endmodule

### rtl/opcode_pattern_scanner_top.sv
// Top level of the opcode pattern scanner: APB register file, input stage,
// byte window, match check and result register. Depends on ops_pkg,
// ops_byte_if, ops_match_if and ops_matcher.

// The scanner takes one code byte per cycle on byte_stream and reports each
// opcode pattern found on match_stream, as table index, base_address plus start
// offset, and running match number of the scan. A start offset is checked
// once the byte that completes its WINDOW_BYTES window arrives, and only while
// offset + 16 < scan_length; at most max_matches reports come per scan, and
// an item with first set starts a new scan. Throughput is one item per clock
// while reports are taken: an accepted byte is held in the input register,
// where the window compare, offset check and address add run, and its report
// then goes to the result register. A report that is not taken stalls the
// input register, and with it byte_stream.ready, only once that register also
// holds a byte. Registers are to be written over APB only while the stream is
// idle; the block itself does not enforce this. base_address is at 0x00,
// scan_length at 0x08, max_matches at 0x10, all 64-bit words.
module opcode_pattern_scanner_top #(
	parameter int WINDOW_BYTES = ops_pkg::WINDOW_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	ops_byte_if.sink                     byte_stream,
	ops_match_if.source                  match_stream,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ops_pkg::PADDR_W-1:0]  paddr,
	input  logic [ops_pkg::PDATA_W-1:0]  pwdata,
	output logic [ops_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int                           WIN_W = ops_pkg::BYTE_W * WINDOW_BYTES;
	localparam logic [ops_pkg::LENGTH_W-1:0] LAG   = ops_pkg::LENGTH_W'(WINDOW_BYTES - 1);
	localparam logic [ops_pkg::LENGTH_W:0]   GUARD = (ops_pkg::LENGTH_W + 1)'(ops_pkg::TAIL_GUARD);

	// Configuration registers
	logic [ops_pkg::ADDR_W-1:0]   base_q;
	logic [ops_pkg::LENGTH_W-1:0] len_q;
	logic [ops_pkg::NUMBER_W-1:0] max_q;
	ops_pkg::reg_idx_t            reg_idx;
	logic                         wr_en;

	assign pready  = 1'b1;
	assign reg_idx = ops_pkg::reg_idx_t'(paddr[4:3]);
	assign wr_en   = psel & penable & pwrite;

	// Take a register write in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= ops_pkg::BASE_RESET;
			len_q  <= ops_pkg::LEN_RESET;
			max_q  <= ops_pkg::MAX_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				ops_pkg::REG_BASE_ADDRESS: base_q <= pwdata;
				ops_pkg::REG_SCAN_LENGTH:  len_q  <= pwdata[ops_pkg::LENGTH_W-1:0];
				ops_pkg::REG_MAX_MATCHES:  max_q  <= pwdata[ops_pkg::NUMBER_W-1:0];
				ops_pkg::REG_UNUSED:       ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_idx)
			ops_pkg::REG_BASE_ADDRESS: prdata = base_q;
			ops_pkg::REG_SCAN_LENGTH:  prdata = ops_pkg::PDATA_W'(len_q);
			ops_pkg::REG_MAX_MATCHES:  prdata = ops_pkg::PDATA_W'(max_q);
			ops_pkg::REG_UNUSED:       prdata = '0;
		endcase
	end

	// Input register and handshake
	logic                       valid_s1;
	logic [ops_pkg::BYTE_W-1:0] code_s1;
	logic                       first_s1;
	logic                       out_valid_q;
	logic                       advance;
	logic                       take;

	assign advance           = valid_s1 & (~out_valid_q | match_stream.ready);
	assign byte_stream.ready = ~valid_s1 | advance;
	assign take              = byte_stream.valid & byte_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	// Hold the accepted byte
	always_ff @(posedge clk) begin
		if (take) begin
			code_s1  <= byte_stream.code_byte;
			first_s1 <= byte_stream.first;
		end
	end

	// Scan state, cleared by an item with first set
	logic [ops_pkg::LENGTH_W-1:0] pos_q;
	logic [ops_pkg::NUMBER_W-1:0] count_q;
	logic [ops_pkg::LENGTH_W-1:0] pos_eff;
	logic [ops_pkg::NUMBER_W-1:0] count_eff;
	logic [WIN_W-1:0]             window;

	assign pos_eff   = first_s1 ? '0 : pos_q;
	assign count_eff = first_s1 ? '0 : count_q;

	// Older bytes of the window, oldest in the low byte
	if (WINDOW_BYTES > 1) begin : g_hist
		logic [WIN_W-ops_pkg::BYTE_W-1:0] hist_q;

		assign window = {code_s1, (first_s1 ? '0 : hist_q)};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hist_q <= '0;
			end else if (advance) begin
				hist_q <= window[WIN_W-1:ops_pkg::BYTE_W];
			end
		end
	end else begin : g_nohist
		assign window = code_s1;
	end

	// Compare the window against the table
	ops_pkg::match_t match;

	ops_matcher #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_matcher (
		.window(window),
		.result(match)
	);

	// Settle the start offset and decide on a report
	logic [ops_pkg::LENGTH_W-1:0] offset;
	logic                         settled;
	logic                         report;

	assign offset  = pos_eff - LAG;
	assign settled = (pos_eff >= LAG) &&
		(({1'b0, offset} + GUARD) < {1'b0, len_q});
	assign report  = settled & match.hit & (count_eff < max_q);

	// Advance position (saturating) and match count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
		end else if (advance) begin
			pos_q   <= (pos_eff == '1) ? pos_eff : pos_eff + 1'b1;
			count_q <= report ? count_eff + 1'b1 : count_eff;
		end
	end

	// Result register
	logic [ops_pkg::INDEX_W-1:0]  index_q;
	logic [ops_pkg::ADDR_W-1:0]   addr_q;
	logic [ops_pkg::NUMBER_W-1:0] number_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= report;
		end else if (match_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the report payload
	always_ff @(posedge clk) begin
		if (advance & report) begin
			index_q  <= match.index;
			addr_q   <= base_q + ops_pkg::ADDR_W'(offset);
			number_q <= count_eff + 1'b1;
		end
	end

	assign match_stream.valid         = out_valid_q;
	assign match_stream.pattern_index = index_q;
	assign match_stream.match_address = addr_q;
	assign match_stream.match_number  = number_q;

endmodule

### dv/tb.sv
// Self-checking testbench for opcode_pattern_scanner_top: drives code bytes and APB
// register writes, predicts match reports and checks every report field by field.
// Depends on ops_pkg, ops_byte_if, ops_match_if and the RTL of the scanner.
`timescale 1ns / 1ps

module tb;

	// One expected match report
	typedef struct {
		logic [ops_pkg::INDEX_W-1:0]  pattern_index;
		logic [ops_pkg::ADDR_W-1:0]   match_address;
		logic [ops_pkg::NUMBER_W-1:0] match_number;
	} match_rec_t;

	// One opcode pattern: length in bytes, bytes left-aligned
	typedef struct {
		int          len;
		logic [39:0] bytes;
	} opcode_t;

	localparam int OPCODES = 24;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ops_pkg::PADDR_W-1:0] paddr;
	logic [ops_pkg::PDATA_W-1:0] pwdata;
	logic [ops_pkg::PDATA_W-1:0] prdata;
	logic pready;

	ops_byte_if  byte_ch ();
	ops_match_if match_ch ();

	opcode_pattern_scanner_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_stream  (byte_ch),
		.match_stream (match_ch),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Register copies and scanner state as the predictor sees them
	logic [ops_pkg::ADDR_W-1:0]   cfg_base  = '0;
	logic [ops_pkg::LENGTH_W-1:0] cfg_len   = 16'd400;
	logic [ops_pkg::NUMBER_W-1:0] cfg_max   = 8'd50;
	logic [31:0]                  older_q   = '0;
	logic [15:0]                  pos_q     = '0;
	logic [7:0]                   hits_q    = '0;

	match_rec_t  expected_matches[$];
	logic [7:0]  code_q[$];
	int          fail_count  = 0;
	int          item_count  = 0;
	int          match_count = 0;
	int          hold_len    = 0;
	bit          no_idle     = 0;

	// Fixed opcode table, in report order
	function automatic opcode_t opcode_entry(input int idx);
		opcode_t e;
		case (idx)
			0:  e = '{4, 40'h48_8d_04_89_00};
			1:  e = '{4, 40'h48_8d_04_49_00};
			2:  e = '{4, 40'h48_8d_04_c9_00};
			3:  e = '{4, 40'h48_c1_e0_08_00};
			4:  e = '{4, 40'h48_c1_e0_09_00};
			5:  e = '{4, 40'h48_c1_e0_0a_00};
			6:  e = '{5, 40'hb8_00_04_00_00};
			7:  e = '{5, 40'hb8_00_05_00_00};
			8:  e = '{2, 40'h48_39_00_00_00};
			9:  e = '{1, 40'h39_00_00_00_00};
			10: e = '{1, 40'h69_00_00_00_00};
			11: e = '{1, 40'h6b_00_00_00_00};
			12: e = '{2, 40'h48_f7_00_00_00};
			13: e = '{2, 40'h0f_8c_00_00_00};
			14: e = '{2, 40'h0f_8d_00_00_00};
			15: e = '{2, 40'h0f_82_00_00_00};
			16: e = '{2, 40'h0f_83_00_00_00};
			17: e = '{2, 40'h0f_84_00_00_00};
			18: e = '{2, 40'h0f_85_00_00_00};
			19: e = '{2, 40'h48_01_00_00_00};
			20: e = '{2, 40'h48_29_00_00_00};
			21: e = '{2, 40'h48_21_00_00_00};
			22: e = '{2, 40'h48_09_00_00_00};
			default: e = '{2, 40'h48_31_00_00_00};
		endcase
		return e;
	endfunction

	// Advance the scanner state by one accepted byte and queue any report it settles
	task automatic predict_matches(input logic [7:0] b, input logic f);
		logic [39:0]  win;
		int unsigned  s;
		opcode_t      e;
		bit           hit;
		bit           settled;
		match_rec_t   m;
		if (f) begin
			older_q = '0;
			pos_q   = '0;
			hits_q  = '0;
		end
		win = {older_q, b};
		settled = 0;
		if (pos_q >= 16'd4) begin
			s = pos_q - 16'd4;
			if (s + 16 < cfg_len) begin
				for (int p = 0; p < OPCODES; p++) begin
					if (!settled) begin
						e = opcode_entry(p);
						hit = (e.len <= 5);
						for (int j = 0; j < e.len; j++)
							if (win[39-8*j -: 8] != e.bytes[39-8*j -: 8])
								hit = 0;
						if (hit) begin
							settled = 1;
							if (hits_q < cfg_max) begin
								hits_q = hits_q + 8'd1;
								m.pattern_index = p[ops_pkg::INDEX_W-1:0];
								m.match_address = cfg_base + ops_pkg::ADDR_W'(s);
								m.match_number  = hits_q;
								expected_matches.push_back(m);
							end
						end
					end
				end
			end
		end
		older_q = win[31:0];
		if (pos_q != 16'hffff)
			pos_q = pos_q + 16'd1;
	endtask

	// Offer one byte after a random gap and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic f);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.code_byte <= b;
		byte_ch.first     <= f;
		do @(posedge clk); while (!byte_ch.ready);
		predict_matches(b, f);
		item_count++;
	endtask

	// Send code_q as one scan; stray restarts mid-scan when asked
	task automatic send_scan(input bit stray);
		logic f;
		foreach (code_q[i]) begin
			f = (i == 0) || (stray && $urandom_range(0, 39) == 0);
			send_byte(code_q[i], f);
		end
	endtask

	// Drop valid, wait for every expected report, then let the pipeline empty
	task automatic drain();
		int guard;
		guard = 0;
		byte_ch.valid <= 1'b0;
		while (expected_matches.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input ops_pkg::reg_idx_t r,
		input logic [ops_pkg::PDATA_W-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(input ops_pkg::reg_idx_t r,
		output logic [ops_pkg::PDATA_W-1:0] d);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {r, 3'b000};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		d = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Read a register back and compare it with the predictor's copy
	task automatic check_reg(input ops_pkg::reg_idx_t r);
		logic [ops_pkg::PDATA_W-1:0] d;
		logic [ops_pkg::PDATA_W-1:0] exp_val;
		logic [ops_pkg::PDATA_W-1:0] mask;
		apb_read(r, d);
		case (r)
			ops_pkg::REG_BASE_ADDRESS: begin
				exp_val = cfg_base;
				mask    = '1;
			end
			ops_pkg::REG_SCAN_LENGTH: begin
				exp_val = ops_pkg::PDATA_W'(cfg_len);
				mask    = ops_pkg::PDATA_W'(16'hffff);
			end
			default: begin
				exp_val = ops_pkg::PDATA_W'(cfg_max);
				mask    = ops_pkg::PDATA_W'(8'hff);
			end
		endcase
		if ((d & mask) != exp_val) begin
			$display("%0t: register %s readback mismatch, expected %0h, actual %0h",
				$time, r.name(), exp_val, d & mask);
			fail_count++;
		end
	endtask

	// Write a register while the stream is idle and mirror it in the predictor
	task automatic set_reg(input ops_pkg::reg_idx_t r,
		input logic [ops_pkg::PDATA_W-1:0] v);
		drain();
		apb_write(r, v);
		case (r)
			ops_pkg::REG_BASE_ADDRESS: cfg_base = v;
			ops_pkg::REG_SCAN_LENGTH:  cfg_len  = v[ops_pkg::LENGTH_W-1:0];
			ops_pkg::REG_MAX_MATCHES:  cfg_max  = v[ops_pkg::NUMBER_W-1:0];
			default: ;
		endcase
		check_reg(r);
	endtask

	task automatic fill_code(input logic [7:0] b, input int n);
		code_q.delete();
		repeat (n) code_q.push_back(b);
	endtask

	// Reset values, then one scan with the default settings
	task automatic test_reset_values();
		check_reg(ops_pkg::REG_BASE_ADDRESS);
		check_reg(ops_pkg::REG_SCAN_LENGTH);
		check_reg(ops_pkg::REG_MAX_MATCHES);
		code_q = '{8'h0f, 8'h84, 8'h00, 8'hff, 8'h00};
		send_scan(0);
	endtask

	// Scan lengths of 16 and 0 check no offset at all
	task automatic test_short_scan();
		set_reg(ops_pkg::REG_SCAN_LENGTH, 64'd16);
		fill_code(8'h39, 6);
		send_scan(0);
		set_reg(ops_pkg::REG_SCAN_LENGTH, 64'd0);
		send_scan(0);
	endtask

	// No reports with a limit of zero, then hits past the limit dropped
	task automatic test_match_limit();
		set_reg(ops_pkg::REG_SCAN_LENGTH, 64'd65535);
		set_reg(ops_pkg::REG_MAX_MATCHES, 64'd0);
		fill_code(8'h39, 7);
		send_scan(0);
		set_reg(ops_pkg::REG_MAX_MATCHES, 64'd2);
		fill_code(8'h69, 8);
		send_scan(0);
	endtask

	// Only offsets clear of the tail are checked; addresses wrap past the top
	task automatic test_scan_tail();
		set_reg(ops_pkg::REG_MAX_MATCHES, 64'd255);
		set_reg(ops_pkg::REG_SCAN_LENGTH, 64'd18);
		set_reg(ops_pkg::REG_BASE_ADDRESS, '1);
		code_q = '{8'h69, 8'h6b, 8'h39, 8'hff, 8'h00, 8'h00, 8'h00};
		send_scan(0);
	endtask

	// A new scan right behind the last one restarts offsets and match numbers
	task automatic test_restart();
		set_reg(ops_pkg::REG_SCAN_LENGTH, 64'd400);
		set_reg(ops_pkg::REG_BASE_ADDRESS, {$urandom, $urandom});
		code_q = '{8'h48, 8'h31, 8'h39, 8'h00, 8'h00, 8'h00};
		send_scan(0);
		send_scan(0);
	endtask

	// Hold off the report side while a dense scan keeps coming
	task automatic test_backpressure();
		set_reg(ops_pkg::REG_SCAN_LENGTH, 64'd65535);
		no_idle  = 1;
		hold_len = 60;
		fill_code(8'h39, 40);
		send_scan(0);
		no_idle = 0;
	endtask

	// Random settings, each with scans built mostly from table patterns
	task automatic test_random_scans();
		int       budget;
		int       nbytes;
		int       k;
		int       cut;
		opcode_t  e;
		logic [ops_pkg::ADDR_W-1:0]   base_v;
		logic [ops_pkg::LENGTH_W-1:0] len_v;
		logic [ops_pkg::NUMBER_W-1:0] max_v;
		for (int ph = 0; ph < 8; ph++) begin
			base_v = (ph == 0) ? '0 : (ph == 1) ? '1 : {$urandom, $urandom};
			len_v  = (ph == 3) ? 16'd65535 : (ph == 5) ? 16'd17 :
				(ph == 6) ? 16'd400 : 16'($urandom_range(17, 60));
			max_v  = (ph == 0) ? 8'd255 : (ph == 1) ? 8'd0 : (ph == 2) ? 8'd1 :
				($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(1, 12));
			set_reg(ops_pkg::REG_BASE_ADDRESS, base_v);
			set_reg(ops_pkg::REG_SCAN_LENGTH, 64'(len_v));
			set_reg(ops_pkg::REG_MAX_MATCHES, 64'(max_v));
			no_idle = (ph % 3 == 2);
			budget = 95;
			while (budget > 0) begin
				nbytes = (cfg_len > 200) ? $urandom_range(12, 80) :
					int'(cfg_len) + $urandom_range(0, 6);
				if (nbytes > budget)
					nbytes = budget;
				code_q.delete();
				while (code_q.size() < nbytes) begin
					k = $urandom_range(0, 19);
					e = opcode_entry($urandom_range(0, OPCODES - 1));
					if (k < 12) begin
						// whole pattern
						for (int j = 0; j < e.len; j++)
							code_q.push_back(e.bytes[39-8*j -: 8]);
					end else if (k < 15) begin
						// near miss: last byte of the pattern flipped
						cut = e.len - 1;
						for (int j = 0; j < cut; j++)
							code_q.push_back(e.bytes[39-8*j -: 8]);
						code_q.push_back(e.bytes[39-8*cut -: 8] ^
							(8'h01 << $urandom_range(0, 7)));
					end else if (k < 17) begin
						code_q.push_back(($urandom_range(0, 1) == 1) ? 8'h48 : 8'h0f);
						code_q.push_back(8'($urandom));
					end else begin
						code_q.push_back(8'($urandom));
					end
				end
				while (code_q.size() > nbytes)
					void'(code_q.pop_back());
				send_scan(1);
				budget -= nbytes;
			end
		end
		no_idle = 0;
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Report side: random stalls, plus a long hold when a test asks for one
	initial begin
		int stall;
		match_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_len > 0) begin
				match_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				match_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			match_ch.ready <= 1'b1;
			do @(posedge clk); while (!match_ch.valid);
		end
	end

	// Compare each accepted report with the oldest expectation
	always @(posedge clk) begin : check_matches
		match_rec_t exp_m;
		if (arst_n && match_ch.valid && match_ch.ready) begin
			match_count++;
			if (expected_matches.size() == 0) begin
				$display("%0t: unexpected report, expected none, actual index %0d addr %0h num %0d",
					$time, match_ch.pattern_index, match_ch.match_address,
					match_ch.match_number);
				fail_count++;
			end else begin
				exp_m = expected_matches.pop_front();
				if (match_ch.pattern_index !== exp_m.pattern_index) begin
					$display("%0t: pattern_index mismatch, expected %0d, actual %0d",
						$time, exp_m.pattern_index, match_ch.pattern_index);
					fail_count++;
				end
				if (match_ch.match_address !== exp_m.match_address) begin
					$display("%0t: match_address mismatch, expected %0h, actual %0h",
						$time, exp_m.match_address, match_ch.match_address);
					fail_count++;
				end
				if (match_ch.match_number !== exp_m.match_number) begin
					$display("%0t: match_number mismatch, expected %0d, actual %0d",
						$time, exp_m.match_number, match_ch.match_number);
					fail_count++;
				end
			end
		end
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Test sequence
	initial begin
		arst_n            <= 1'b0;
		byte_ch.valid     <= 1'b0;
		byte_ch.code_byte <= '0;
		byte_ch.first     <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_short_scan();
		test_match_limit();
		test_scan_tail();
		test_restart();
		test_backpressure();
		test_random_scans();

		drain();
		repeat (10) @(posedge clk);
		if (expected_matches.size() != 0) begin
			$display("%0t: %0d reports expected but never seen, actual 0",
				$time, expected_matches.size());
			fail_count++;
		end
		$display("Scanned %0d code bytes and checked %0d match reports", item_count,
			match_count);
		$display("Covered short and long scans, match limits, restarts, stalls and wrapping addresses");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
